[design/ssmd_pkg.sv]
// Package for the multiplexed seven-segment display unit: operation codes,
// register indexes, pipeline stage types and the character glyph tables.
// No dependencies.
`default_nettype none

package ssmd_pkg;

  localparam int unsigned Digits = 4;

  localparam logic [7:0] RawMark   = 8'h80;
  localparam logic [7:0] SpaceCode = 8'h20;

  localparam logic [6:0] BrightMax   = 7'd100;
  localparam logic [6:0] BrightReset = 7'd25;
  localparam logic [6:0] PeriodBase  = 7'd105;

  // configuration register indexes
  localparam logic [1:0] CfgBrightness    = 2'd0;
  localparam logic [1:0] CfgCommonCathode = 2'd1;
  localparam logic [1:0] CfgAlphabet      = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SHIFT_CHR = 3'd1,
    OP_WRITE_CHR = 3'd2,
    OP_WRITE_PAT = 3'd3,
    OP_SHIFT_PAT = 3'd4,
    OP_NUMBER    = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_TIME      = 3'd7
  } op_e;

  // fields of a command that travel through every stage
  typedef struct packed {
    op_e        op;
    logic [7:0] code;
    logic [7:0] pat;
    logic [1:0] pos;
    logic       sec_odd;
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] number;
    logic [6:0]  hours;
    logic [6:0]  minutes;
  } stg0_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] value;
  } stg1_t;

  // value = 100 * quo + rem
  typedef struct packed {
    cmd_t       cmd;
    logic [9:0] quo;
    logic [6:0] rem;
  } stg2_t;

  // n < 100 -> {tens, ones}; n*205 >> 11 is exact n/10 for this range
  function automatic logic [7:0] split_dec(input logic [6:0] n);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(n) * 15'd205;
    tens = prod[14:11];
    ones = n - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] base_glyph(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      8'h00, 8'h30, 8'h4F:        s = 8'h3F;
      8'h01, 8'h31, 8'h6C:        s = 8'h06;
      8'h02, 8'h32:               s = 8'h5B;
      8'h03, 8'h33:               s = 8'h4F;
      8'h04, 8'h34:               s = 8'h66;
      8'h05, 8'h35, 8'h53, 8'h73: s = 8'h6D;
      8'h06, 8'h36:               s = 8'h7D;
      8'h07, 8'h37:               s = 8'h07;
      8'h08, 8'h38:               s = 8'h7F;
      8'h09, 8'h39, 8'h67:        s = 8'h6F;
      8'h0A, 8'h41, 8'h61:        s = 8'h77;
      8'h0B, 8'h42, 8'h62:        s = 8'h7C;
      8'h0C, 8'h43:               s = 8'h39;
      8'h63:                      s = 8'h58;
      8'h0D, 8'h44, 8'h64:        s = 8'h5E;
      8'h0E, 8'h45:               s = 8'h79;
      8'h65:                      s = 8'h7B;
      8'h0F, 8'h46, 8'h66:        s = 8'h71;
      default:                    s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] extra_glyph(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      8'h47:                      s = 8'h3D;
      8'h48:                      s = 8'h76;
      8'h68:                      s = 8'h74;
      8'h49, 8'h69:               s = 8'h06;
      8'h4A, 8'h6A:               s = 8'h1E;
      8'h4C:                      s = 8'h38;
      8'h4D, 8'h6D:               s = 8'h55;
      8'h4E, 8'h6E:               s = 8'h54;
      8'h6F:                      s = 8'h5C;
      8'h50, 8'h70:               s = 8'h73;
      8'h51, 8'h71:               s = 8'h67;
      8'h52, 8'h72:               s = 8'h50;
      8'h54, 8'h74:               s = 8'h78;
      8'h55:                      s = 8'h3E;
      8'h75, 8'h56, 8'h76:        s = 8'h1C;
      8'h57, 8'h77:               s = 8'h1D;
      8'h59, 8'h79:               s = 8'h6E;
      8'h2D:                      s = 8'h40;
      8'h22:                      s = 8'h22;
      8'h27:                      s = 8'h02;
      8'h5F:                      s = 8'h08;
      default:                    s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] glyph(input logic [7:0] c, input logic alpha);
    logic [7:0] s;
    s = base_glyph(c);
    if (s == 8'h00 && alpha) begin
      s = extra_glyph(c);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[design/seven_segment_mux_display_unit.sv]
// Top level of the multiplexed four-digit seven-segment display unit.
// Uses ssmd_pkg for codes, stage types and glyph tables.
`default_nettype none

// Takes one command per clock while the input is not stalled and returns one
// result (the digit and segment pin levels after that command) per command, in
// order. A result passes four registers in a row: the input register, one
// after the time value is formed, one after the split of the value into a
// quotient and remainder by 100, and the output register, loaded as the
// command commits its decimal digits or other update to the display state.
// Ticks advance the multiplex counter; other commands leave the pin levels
// unchanged. Polarity follows the cathode-polarity register at the time the
// command commits.
module seven_segment_mux_display_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [7:0]  segment_pattern_i,
  input  wire logic [1:0]  position_i,
  input  wire logic [15:0] number_i,
  input  wire logic [6:0]  hours_i,
  input  wire logic [6:0]  minutes_i,
  input  wire logic [5:0]  seconds_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       digit_lines_o,
  output logic [7:0]       segment_lines_o
);

  // configuration
  logic [6:0] bright_q;
  logic       cc_q;
  logic       alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= ssmd_pkg::BrightReset;
      cc_q     <= 1'b0;
      alpha_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssmd_pkg::CfgBrightness:    bright_q <= cfg_wdata_i;
        ssmd_pkg::CfgCommonCathode: cc_q     <= cfg_wdata_i[0];
        ssmd_pkg::CfgAlphabet:      alpha_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_free, s1_free, s0_free;
  logic s2_go, s1_go, s0_go, in_take;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s2_go    = s2_valid_q && out_free;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_go    = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign s0_go    = s0_valid_q && s1_free;
  assign s0_free  = !s0_valid_q || s1_free;
  assign in_take  = in_valid_i && s0_free;

  assign in_stall_o  = !s0_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_free)  s0_valid_q  <= in_valid_i;
      if (s1_free)  s1_valid_q  <= s0_valid_q;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (out_free) out_valid_q <= s2_valid_q;
    end
  end

  // stage 0: input register, form the value to show
  ssmd_pkg::stg0_t s0_q;
  ssmd_pkg::stg1_t s1_d, s1_q;
  logic [13:0]     time_val;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s0_q.cmd.op      <= ssmd_pkg::op_e'(operation_i);
      s0_q.cmd.code    <= char_code_i;
      s0_q.cmd.pat     <= segment_pattern_i;
      s0_q.cmd.pos     <= position_i;
      s0_q.cmd.sec_odd <= seconds_i[0];
      s0_q.number      <= number_i;
      s0_q.hours       <= hours_i;
      s0_q.minutes     <= minutes_i;
    end
  end

  always_comb begin
    time_val   = 14'(s0_q.hours) * 14'd100 + 14'(s0_q.minutes);
    s1_d.cmd   = s0_q.cmd;
    s1_d.value = (s0_q.cmd.op == ssmd_pkg::OP_TIME) ? {2'b00, time_val} : s0_q.number;
  end

  always_ff @(posedge clk_i) begin
    if (s0_go) s1_q <= s1_d;
  end

  // stage 1: value / 100 by reciprocal; the estimate is at most one low
  ssmd_pkg::stg2_t s2_d, s2_q;
  logic [25:0] recip_prod;
  logic [9:0]  quo_est;
  logic [16:0] rem_full;
  logic [7:0]  rem_est;

  always_comb begin
    recip_prod = 26'(s1_q.value) * 26'd655;
    quo_est    = recip_prod[25:16];
    rem_full   = 17'(s1_q.value) - 17'(quo_est) * 17'd100;
    rem_est    = rem_full[7:0];
    s2_d.cmd   = s1_q.cmd;
    if (rem_est >= 8'd100) begin
      s2_d.quo = quo_est + 10'd1;
      s2_d.rem = 7'(rem_est - 8'd100);
    end else begin
      s2_d.quo = quo_est;
      s2_d.rem = rem_est[6:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) s2_q <= s2_d;
  end

  // stage 2: digits and commit to display state
  logic [15:0] hund_prod;
  logic [2:0]  hund_hi;
  logic [9:0]  hund_lo_full;
  logic [7:0]  hi_dec, lo_dec;

  always_comb begin
    hund_prod    = 16'(s2_q.quo) * 16'd41;
    hund_hi      = hund_prod[14:12];
    hund_lo_full = s2_q.quo - 10'(hund_hi) * 10'd100;
    hi_dec       = ssmd_pkg::split_dec(hund_lo_full[6:0]);
    lo_dec       = ssmd_pkg::split_dec(s2_q.rem);
  end

  logic [7:0] char_q [ssmd_pkg::Digits];
  logic [7:0] char_d [ssmd_pkg::Digits];
  logic [7:0] pat_q  [ssmd_pkg::Digits];
  logic [7:0] pat_d  [ssmd_pkg::Digits];
  logic [3:0] dots_q, dots_d;
  logic [6:0] mux_cnt_q, mux_cnt_d;
  logic [3:0] digit_drive_q, digit_drive_d;
  logic [7:0] seg_drive_q, seg_drive_d;

  logic [6:0] bright_eff;
  logic [6:0] period;
  logic [6:0] cnt_inc;
  logic [1:0] sel;
  logic [1:0] dot_idx;
  logic [7:0] sel_char;
  logic [7:0] sel_segs;

  always_comb begin
    bright_eff = (bright_q > ssmd_pkg::BrightMax) ? ssmd_pkg::BrightMax : bright_q;
    period     = ssmd_pkg::PeriodBase - bright_eff;
    cnt_inc    = mux_cnt_q + 7'd1;
    sel        = mux_cnt_q[1:0];
    dot_idx    = sel + 2'd1;
    sel_char   = char_q[sel];
    if (sel_char[7]) begin
      sel_segs = pat_q[sel];
    end else begin
      sel_segs = ssmd_pkg::glyph(sel_char, alpha_q);
    end
    // rightmost digit has no flag bit for its dot
    if (sel != 2'd3 && dots_q[dot_idx]) begin
      sel_segs = sel_segs | ssmd_pkg::RawMark;
    end

    char_d        = char_q;
    pat_d         = pat_q;
    dots_d        = dots_q;
    mux_cnt_d     = mux_cnt_q;
    digit_drive_d = digit_drive_q;
    seg_drive_d   = seg_drive_q;

    if (s2_go) begin
      case (s2_q.cmd.op)
        ssmd_pkg::OP_TICK: begin
          if (mux_cnt_q < 7'(ssmd_pkg::Digits)) begin
            digit_drive_d = 4'b0001 << sel;
            seg_drive_d   = sel_segs;
          end else if (mux_cnt_q == 7'(ssmd_pkg::Digits)) begin
            digit_drive_d = 4'b0000;
            seg_drive_d   = 8'h00;
          end
          mux_cnt_d = (cnt_inc >= period) ? 7'd0 : cnt_inc;
        end
        ssmd_pkg::OP_SHIFT_CHR: begin
          for (int i = 0; i < ssmd_pkg::Digits - 1; i++) begin
            char_d[i] = char_q[i + 1];
            pat_d[i]  = pat_q[i + 1];
          end
          char_d[ssmd_pkg::Digits - 1] = s2_q.cmd.code;
          pat_d[ssmd_pkg::Digits - 1]  = 8'h00;
        end
        ssmd_pkg::OP_WRITE_CHR: begin
          char_d[s2_q.cmd.pos] = s2_q.cmd.code;
        end
        ssmd_pkg::OP_WRITE_PAT: begin
          pat_d[s2_q.cmd.pos]  = s2_q.cmd.pat;
          char_d[s2_q.cmd.pos] = ssmd_pkg::RawMark;
        end
        ssmd_pkg::OP_SHIFT_PAT: begin
          for (int i = 0; i < ssmd_pkg::Digits - 1; i++) begin
            char_d[i] = char_q[i + 1];
            pat_d[i]  = pat_q[i + 1];
          end
          char_d[ssmd_pkg::Digits - 1] = ssmd_pkg::RawMark;
          pat_d[ssmd_pkg::Digits - 1]  = s2_q.cmd.pat;
        end
        ssmd_pkg::OP_NUMBER, ssmd_pkg::OP_TIME: begin
          char_d[0] = {4'h0, hi_dec[7:4]};
          char_d[1] = {4'h0, hi_dec[3:0]};
          char_d[2] = {4'h0, lo_dec[7:4]};
          char_d[3] = {4'h0, lo_dec[3:0]};
          // colon dot sits on flag bit 2 and follows second parity
          if (s2_q.cmd.op == ssmd_pkg::OP_TIME) begin
            dots_d = {1'b0, s2_q.cmd.sec_odd, 2'b00};
          end else begin
            dots_d = 4'h0;
          end
        end
        ssmd_pkg::OP_CLEAR: begin
          for (int i = 0; i < ssmd_pkg::Digits; i++) begin
            char_d[i] = ssmd_pkg::SpaceCode;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ssmd_pkg::Digits; i++) begin
        char_q[i] <= ssmd_pkg::SpaceCode;
        pat_q[i]  <= 8'h00;
      end
      dots_q        <= 4'h0;
      mux_cnt_q     <= 7'd0;
      digit_drive_q <= 4'h0;
      seg_drive_q   <= 8'h00;
    end else begin
      char_q        <= char_d;
      pat_q         <= pat_d;
      dots_q        <= dots_d;
      mux_cnt_q     <= mux_cnt_d;
      digit_drive_q <= digit_drive_d;
      seg_drive_q   <= seg_drive_d;
    end
  end

  // output register, pin polarity applied
  logic [3:0] digit_lines_q;
  logic [7:0] segment_lines_q;

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      digit_lines_q   <= cc_q ? ~digit_drive_d : digit_drive_d;
      segment_lines_q <= cc_q ? seg_drive_d : ~seg_drive_d;
    end
  end

  assign digit_lines_o   = digit_lines_q;
  assign segment_lines_o = segment_lines_q;

  // at most one digit is ever driven
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(digit_drive_q))
    else $error("more than one digit driven");

  // blanked digits always come with blank segments
  a_blank_segs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_drive_q == 4'h0) |-> (seg_drive_q == 8'h00))
    else $error("segments lit with no digit driven");

  // only a tick moves the multiplex state
  a_cmd_keeps_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && s2_q.cmd.op != ssmd_pkg::OP_TICK) |=>
      ($stable(digit_drive_q) && $stable(seg_drive_q) && $stable(mux_cnt_q)))
    else $error("non-tick command changed the multiplex state");

endmodule

`default_nettype wire
